// File: design/mmr_pkg.sv
`timescale 1ns / 1ps
package mmr_pkg;
  localparam int SAMPLE_W = 16;
  localparam int RESULT_W = 48;
  localparam int POS_W = 12;
  localparam int COUNT_W = 13;
  localparam int NUM_LANES = 4;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef enum logic [2:0] {
    OP_SUM = 3'd0,
    OP_SUMSQ = 3'd1,
    OP_AVG = 3'd2,
    OP_MAX = 3'd3,
    OP_MIN = 3'd4
  } op_t;

  localparam logic [1:0] REG_OPERATION = 2'd0;
  localparam logic [1:0] REG_DIRECTION = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  // divider request
  typedef struct packed {
    logic [NUM_LANES-1:0][RESULT_W-1:0] acc;
    logic [COUNT_W-1:0] count;
    logic divide;
    logic [POS_W-1:0] pos;
    logic last;
  } fin_req_t;
endpackage

// File: design/mmr_finish.sv
`timescale 1ns / 1ps
// rounded average (other results pass through), one quotient bit per cycle for all lanes at once
module mmr_finish #(
  parameter int ACC_BITS = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  output logic req_ready,
  input  mmr_pkg::fin_req_t req,
  output logic res_valid,
  input  logic res_stall,
  output logic [mmr_pkg::NUM_LANES-1:0][mmr_pkg::RESULT_W-1:0] res_acc,
  output logic [mmr_pkg::POS_W-1:0] res_pos,
  output logic res_last
);
  import mmr_pkg::*;

  localparam int CNT_W = $clog2(ACC_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV = 3'b010,
    S_OUT = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [CNT_W-1:0] bit_r;
  logic [NUM_LANES-1:0][ACC_BITS-1:0] quo_r;
  logic [NUM_LANES-1:0][COUNT_W:0] rem_r;
  logic [COUNT_W-1:0] den_r;
  logic div_r;
  logic [NUM_LANES-1:0][RESULT_W-1:0] out_r;
  logic [POS_W-1:0] pos_r;
  logic last_r;

  assign req_ready = (state_r == S_IDLE) || (state_r == S_OUT && !res_stall);
  assign res_valid = (state_r == S_OUT);
  assign res_acc = out_r;
  assign res_pos = pos_r;
  assign res_last = last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (req_valid) state_nxt = req.divide ? S_DIV : S_OUT;
      S_DIV: if (bit_r == '0) state_nxt = S_OUT;
      S_OUT: begin
        if (!res_stall) begin
          if (req_valid) state_nxt = req.divide ? S_DIV : S_OUT;
          else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // restoring division and final rounding
  always_ff @(posedge clk) begin
    logic [COUNT_W+1:0] trial;
    logic [COUNT_W+1:0] twice;
    logic [ACC_BITS-1:0] q;
    if (req_valid && req_ready) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        quo_r[l] <= ACC_BITS'(req.acc[l]);
        rem_r[l] <= '0;
        out_r[l] <= req.acc[l];
      end
      den_r <= req.count;
      div_r <= req.divide;
      pos_r <= req.pos;
      last_r <= req.last;
      bit_r <= CNT_W'(ACC_BITS);
    end else if (state_r == S_DIV) begin
      if (bit_r != '0) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          trial = {rem_r[l], quo_r[l][ACC_BITS-1]};
          if (trial >= {2'b00, den_r}) begin
            rem_r[l] <= (COUNT_W+1)'(trial - {2'b00, den_r});
            quo_r[l] <= {quo_r[l][ACC_BITS-2:0], 1'b1};
          end else begin
            rem_r[l] <= (COUNT_W+1)'(trial);
            quo_r[l] <= {quo_r[l][ACC_BITS-2:0], 1'b0};
          end
        end
        bit_r <= bit_r - 1'b1;
      end else begin
        for (int l = 0; l < NUM_LANES; l++) begin
          twice = {rem_r[l], 1'b0};
          q = quo_r[l];
          if (twice > {2'b00, den_r} || (twice == {2'b00, den_r} && q[0]))
            q = q + 1'b1;
          out_r[l] <= RESULT_W'(q);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && bit_r == '0) |=> (state_r == S_OUT))
    else $error("divider did not finish");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && res_stall) |=> $stable(out_r))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_r && den_r > 1))
    else $error("divide without divisor");
endmodule

// File: design/masked_matrix_reduce_top.sv
`timescale 1ns / 1ps
// each pixel word is captured in idle, read from memory in read, modified and written
//   back in calc (memory read, modify, write back); no new word is taken before calc is
//   done, and a word that ends a result also waits for the finisher to take its request;
//   in average mode a result also waits for the divider to finish the previous result word
// column mode keeps column state in one memory read then written per pixel
// reset (rst_n low, synchronous) clears control and registers; memory is not cleared
module masked_matrix_reduce_top #(
  parameter int MAX_WIDTH = 4096,
  parameter int CHANNELS = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [mmr_pkg::SAMPLE_W-1:0] in_sample_a,
  input  logic [mmr_pkg::SAMPLE_W-1:0] in_sample_b,
  input  logic [mmr_pkg::SAMPLE_W-1:0] in_sample_c,
  input  logic [mmr_pkg::SAMPLE_W-1:0] in_sample_d,
  input  logic in_pixel_mask,
  input  logic in_end_of_row,
  input  logic in_end_of_frame,
  output logic out_valid,
  input  logic out_stall,
  output logic [mmr_pkg::RESULT_W-1:0] out_result_a,
  output logic [mmr_pkg::RESULT_W-1:0] out_result_b,
  output logic [mmr_pkg::RESULT_W-1:0] out_result_c,
  output logic [mmr_pkg::RESULT_W-1:0] out_result_d,
  output logic [mmr_pkg::POS_W-1:0] out_position,
  output logic out_last_result
);
  import mmr_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
  localparam logic [ACC_BITS-1:0] SMAX = ACC_BITS'((65'd1 << SAMPLE_BITS) - 1);
  localparam int ENT_W = CHANNELS * ACC_BITS + COUNT_W;

  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_READ = 3'b010,
    P_CALC = 3'b100
  } pstate_t;

  // configuration
  logic [2:0] op_r;
  logic dir_r;
  logic [2:0] chn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_SUM;
      dir_r <= 1'b0;
      chn_r <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPERATION: op_r <= cfg_data;
        REG_DIRECTION: dir_r <= cfg_data[0];
        REG_CHANNELS: chn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2:0] eop;
  logic [2:0] nch;
  always_comb begin
    eop = (op_r > OP_MIN) ? OP_SUM : op_r;
    nch = (chn_r == 3'd0) ? 3'd1 : chn_r;
    if (nch > 3'(CHANNELS)) nch = 3'(CHANNELS);
  end

  // column memory: accumulators and count per column
  logic [ENT_W-1:0] col_mem [MAX_WIDTH];
  logic [ENT_W-1:0] rd_r;

  pstate_t st_r;
  logic [NUM_LANES-1:0][SAMPLE_W-1:0] smp_r;
  logic take_r, eor_r, eof_r;
  logic [COL_W-1:0] col_r;
  logic [POS_W-1:0] row_r;
  logic first_r;
  logic [CHANNELS-1:0][ACC_BITS-1:0] racc_r;
  logic [COUNT_W-1:0] rcnt_r;

  logic fin_valid_r;
  fin_req_t fin_r;
  logic fin_ready;

  assign in_stall = (st_r != P_IDLE) || fin_valid_r;

  // fold one lane
  function automatic logic [ACC_BITS-1:0] fold(input logic [ACC_BITS-1:0] acc,
                                               input logic [SAMPLE_W-1:0] s,
                                               input logic [2:0] op);
    logic [ACC_BITS-1:0] v;
    logic [2*SAMPLE_W-1:0] sq;
    logic [ACC_BITS:0] sum;
    v = ACC_BITS'(s) & SMAX;
    sq = (s & SAMPLE_W'(SMAX)) * (s & SAMPLE_W'(SMAX));
    sum = '0;
    case (op)
      OP_SUMSQ: sum = {1'b0, acc} + (ACC_BITS+1)'(sq);
      OP_MAX: return (v > acc) ? v : acc;
      OP_MIN: return (v < acc) ? v : acc;
      default: sum = {1'b0, acc} + {1'b0, v};
    endcase
    return sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
  endfunction

  logic [CHANNELS-1:0][ACC_BITS-1:0] base;
  logic [COUNT_W-1:0] bcnt;
  logic [CHANNELS-1:0][ACC_BITS-1:0] nacc;
  logic [COUNT_W-1:0] ncnt;
  logic [ACC_BITS-1:0] initv;

  // combine stored state with current pixel
  always_comb begin
    initv = (eop == OP_MIN) ? SMAX : '0;
    if (!dir_r) begin
      for (int c = 0; c < CHANNELS; c++)
        base[c] = first_r ? initv : rd_r[c*ACC_BITS +: ACC_BITS];
      bcnt = first_r ? '0 : rd_r[ENT_W-1 -: COUNT_W];
    end else begin
      for (int c = 0; c < CHANNELS; c++)
        base[c] = (col_r == '0) ? initv : racc_r[c];
      bcnt = (col_r == '0) ? '0 : rcnt_r;
    end
    for (int c = 0; c < CHANNELS; c++)
      nacc[c] = (take_r && 3'(c) < nch) ? fold(base[c], smp_r[c], eop) : base[c];
    ncnt = (take_r && bcnt != COUNT_SAT) ? bcnt + 1'b1 : bcnt;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE;
      col_r <= '0;
      row_r <= '0;
      first_r <= 1'b1;
      fin_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) racc_r[c] <= '0;
      rcnt_r <= '0;
    end else begin
      if (fin_valid_r && fin_ready) fin_valid_r <= 1'b0;
      case (st_r)
        P_IDLE: if (in_valid && !in_stall) st_r <= P_READ;
        P_READ: st_r <= P_CALC;
        P_CALC: begin
          st_r <= P_IDLE;
          if (dir_r) begin
            for (int c = 0; c < CHANNELS; c++)
              if (3'(c) < nch || col_r == '0) racc_r[c] <= nacc[c];
            rcnt_r <= ncnt;
          end
          if ((!dir_r && eof_r) || (dir_r && eor_r)) fin_valid_r <= 1'b1;
          if (eor_r) begin
            col_r <= '0;
            row_r <= eof_r ? '0 : row_r + 1'b1;
            first_r <= eof_r;
          end else begin
            col_r <= (MAX_WIDTH > 1) ? ((32'(col_r) == MAX_WIDTH - 1) ? '0 : col_r + 1'b1)
                                     : '0;
          end
        end
        default: st_r <= P_IDLE;
      endcase
    end
  end

  // payload capture, memory access, finisher request
  always_ff @(posedge clk) begin
    logic [ENT_W-1:0] wr;
    if (in_valid && !in_stall) begin
      smp_r <= {in_sample_d, in_sample_c, in_sample_b, in_sample_a};
      take_r <= in_pixel_mask;
      eor_r <= in_end_of_row;
      eof_r <= in_end_of_frame;
    end
    if (st_r == P_READ) rd_r <= col_mem[col_r];
    if (st_r == P_CALC) begin
      if (!dir_r) begin
        wr = rd_r;
        for (int c = 0; c < CHANNELS; c++)
          if (3'(c) < nch) wr[c*ACC_BITS +: ACC_BITS] = nacc[c];
        wr[ENT_W-1 -: COUNT_W] = ncnt;
        col_mem[col_r] <= wr;
      end
      for (int l = 0; l < NUM_LANES; l++) begin
        if (l < CHANNELS && 3'(l) < nch)
          fin_r.acc[l] <= (ACC_BITS > RESULT_W && |(nacc[l] >> RESULT_W)) ? '1
                          : RESULT_W'(nacc[l]);
        else
          fin_r.acc[l] <= '0;
      end
      fin_r.count <= ncnt;
      fin_r.divide <= (eop == OP_AVG) && (ncnt > 1);
      fin_r.pos <= dir_r ? row_r : POS_W'(col_r);
      fin_r.last <= dir_r ? eof_r : eor_r;
    end
  end

  // average divide operates on saturated 48-bit value (acc <= 2^48-1 holds for ACC_BITS<=48)
  logic [NUM_LANES-1:0][RESULT_W-1:0] res;
  mmr_finish #(.ACC_BITS(RESULT_W)) u_finish (
    .clk(clk), .rst_n(rst_n),
    .req_valid(fin_valid_r), .req_ready(fin_ready), .req(fin_r),
    .res_valid(out_valid), .res_stall(out_stall),
    .res_acc(res), .res_pos(out_position), .res_last(out_last_result)
  );
  assign out_result_a = res[0];
  assign out_result_b = res[1];
  assign out_result_c = res[2];
  assign out_result_d = res[3];

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == P_READ) |=> (st_r == P_CALC))
    else $error("read not followed by update");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != P_IDLE) |-> in_stall)
    else $error("input taken mid update");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == P_CALC && eor_r) |=> (col_r == '0))
    else $error("column not reset at row end");
endmodule

// File: test/mmr_checker.sv
`timescale 1ns / 1ps
module mmr_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [15:0] in_sample_a,
  input  logic [15:0] in_sample_b,
  input  logic [15:0] in_sample_c,
  input  logic [15:0] in_sample_d,
  input  logic in_pixel_mask,
  input  logic in_end_of_row,
  input  logic in_end_of_frame,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [47:0] out_result_a,
  input  logic [47:0] out_result_b,
  input  logic [47:0] out_result_c,
  input  logic [47:0] out_result_d,
  input  logic [11:0] out_position,
  input  logic out_last_result,
  output int fail_count,
  output int pending
);
  import mmr_pkg::*;

  localparam logic [47:0] ACC_TOP = '1;
  localparam int WIDTH = 4096;

  typedef struct packed {
    logic [3:0][47:0] lane;
    logic [11:0] pos;
    logic last;
  } reduced_word_t;

  reduced_word_t expected_words[$];
  logic [47:0] col_acc [WIDTH*4];
  logic [12:0] col_cnt [WIDTH];
  logic [47:0] row_acc [4];
  logic [12:0] row_cnt;
  logic [11:0] col_idx, row_idx;
  logic first_row;
  logic [2:0] op_reg, ch_reg;
  logic dir_reg;

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return (s > ACC_TOP) ? ACC_TOP : s[47:0];
  endfunction

  function automatic logic [47:0] fold_sample(logic [47:0] acc, logic [15:0] v, logic [2:0] op);
    case (op)
      OP_SUMSQ: return sat_sum(acc, 64'(v) * 64'(v));
      OP_MAX:   return (48'(v) > acc) ? 48'(v) : acc;
      OP_MIN:   return (48'(v) < acc) ? 48'(v) : acc;
      default:  return sat_sum(acc, 64'(v));
    endcase
  endfunction

  // rounded average, half to even
  function automatic logic [47:0] finish_lane(logic [47:0] acc, logic [12:0] cnt, logic [2:0] op);
    logic [47:0] q, r;
    if (op != OP_AVG || cnt <= 1) return acc;
    q = acc / cnt;
    r = acc % cnt;
    if (2 * 49'(r) > cnt || (2 * 49'(r) == cnt && q[0])) q++;
    return q;
  endfunction

  // step the predictor on one accepted pixel word
  task automatic predict_pixel(logic [3:0][15:0] s, logic take, logic eor, logic eof);
    logic [2:0] op, nch;
    logic [47:0] init;
    reduced_word_t w;
    op = (op_reg > OP_MIN) ? OP_SUM : op_reg;
    nch = (ch_reg == 0) ? 3'd1 : (ch_reg > 4) ? 3'd4 : ch_reg;
    init = (op == OP_MIN) ? 48'hFFFF : 48'd0;
    w = '0;
    if (!dir_reg) begin
      if (first_row) begin
        for (int c = 0; c < nch; c++) col_acc[col_idx*4+c] = init;
        col_cnt[col_idx] = 0;
      end
      if (take) begin
        for (int c = 0; c < nch; c++)
          col_acc[col_idx*4+c] = fold_sample(col_acc[col_idx*4+c], s[c], op);
        if (col_cnt[col_idx] != COUNT_SAT) col_cnt[col_idx]++;
      end
      if (eof) begin
        for (int c = 0; c < nch; c++)
          w.lane[c] = finish_lane(col_acc[col_idx*4+c], col_cnt[col_idx], op);
        w.pos = col_idx;
        w.last = eor;
        expected_words.push_back(w);
      end
    end else begin
      if (col_idx == 0) begin
        for (int c = 0; c < 4; c++) row_acc[c] = init;
        row_cnt = 0;
      end
      if (take) begin
        for (int c = 0; c < nch; c++) row_acc[c] = fold_sample(row_acc[c], s[c], op);
        if (row_cnt != COUNT_SAT) row_cnt++;
      end
      if (eor) begin
        for (int c = 0; c < nch; c++) w.lane[c] = finish_lane(row_acc[c], row_cnt, op);
        w.pos = row_idx;
        w.last = eof;
        expected_words.push_back(w);
      end
    end
    if (eor) begin
      col_idx = 0;
      row_idx = eof ? 12'd0 : row_idx + 12'd1;
      first_row = eof;
    end else begin
      col_idx++;
    end
  endtask

  always @(posedge clk) begin
    reduced_word_t got, exp_w;
    if (!rst_n) begin
      expected_words.delete();
      for (int c = 0; c < 4; c++) row_acc[c] = 0;
      row_cnt = 0;
      col_idx = 0;
      row_idx = 0;
      first_row = 1;
      op_reg = OP_SUM;
      dir_reg = 0;
      ch_reg = 3'd1;
      fail_count = 0;
    end else begin
      // compare result word with the oldest prediction
      if (out_valid && !out_stall) begin
        got.lane = {out_result_d, out_result_c, out_result_b, out_result_a};
        got.pos = out_position;
        got.last = out_last_result;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_w = expected_words.pop_front();
          if (got != exp_w) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected a=%h b=%h c=%h d=%h pos=%0d last=%b",
                       exp_w.lane[0], exp_w.lane[1], exp_w.lane[2], exp_w.lane[3],
                       exp_w.pos, exp_w.last,
                       "\n          actual   a=%h b=%h c=%h d=%h pos=%0d last=%b",
                       got.lane[0], got.lane[1], got.lane[2], got.lane[3],
                       got.pos, got.last);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_pixel({in_sample_d, in_sample_c, in_sample_b, in_sample_a},
                      in_pixel_mask, in_end_of_row, in_end_of_frame);
      if (cfg_we) begin
        case (cfg_index)
          REG_OPERATION: op_reg = cfg_data;
          REG_DIRECTION: dir_reg = cfg_data[0];
          REG_CHANNELS:  ch_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_words.size();
  end
endmodule

// File: test/tb_masked_matrix_reduce_top.sv
`timescale 1ns / 1ps
module tb_masked_matrix_reduce_top;
  import mmr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] in_sample_a = '0, in_sample_b = '0, in_sample_c = '0, in_sample_d = '0;
  logic in_pixel_mask = 0, in_end_of_row = 0, in_end_of_frame = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [47:0] out_result_a, out_result_b, out_result_c, out_result_d;
  logic [11:0] out_position;
  logic out_last_result;
  int fail_count, pending;
  int pixels_sent;

  always #4 clk = ~clk;

  masked_matrix_reduce_top u_dut (.*);

  mmr_checker u_checker (.*);

  // receiver randomly stalls before taking each word
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 4);
      @(posedge clk);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap - 1) @(posedge clk);
        @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      out_stall <= (gap > 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_mode(logic [2:0] op, logic dir, logic [2:0] nch);
    write_reg(REG_OPERATION, op);
    write_reg(REG_DIRECTION, {2'b0, dir});
    write_reg(REG_CHANNELS, nch);
  endtask

  // wait for every predicted word, then let the pipeline drain
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // one pixel word, driven at the edge that took the previous one or after a random idle gap
  task automatic send_pixel(logic [15:0] a, b, c, d, logic m, eor, eof);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_sample_a <= a;
    in_sample_b <= b;
    in_sample_c <= c;
    in_sample_d <= d;
    in_pixel_mask <= m;
    in_end_of_row <= eor;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic end_burst;
    in_valid <= 0;
  endtask

  function automatic logic [15:0] pick_sample;
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // frame of random content; mask mostly on
  task automatic send_frame(int cols, int rows);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        send_pixel(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                   $urandom_range(0, 7) != 0, c == cols - 1, r == rows - 1);
  endtask

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [2:0] op, nch;
    pixels_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    // directed: extremes for each operation code, alternating direction
    for (int o = 0; o < 8; o++) begin
      op = 3'(o);
      set_mode(op, o[0], (o == 5) ? 3'd0 : (o == 6) ? 3'd7 : 3'(o % 4 + 1));
      send_pixel('1, '1, '1, '1, 1, 0, 0);
      send_pixel('0, '0, '0, '0, 0, 1, 0);
      send_pixel('1, 16'h0001, 16'h8000, 16'h7FFF, 1, 0, 1);
      send_pixel(16'h0003, 16'h0002, 16'h0001, '0, 1, 1, 1);
      end_burst();
      drain();
    end
    // random phases of well-formed frames
    while (pixels_sent < 1500) begin
      op = 3'($urandom_range(0, 7));
      nch = 3'($urandom_range(0, 7));
      set_mode(op, 1'($urandom_range(0, 1)), nch);
      repeat ($urandom_range(1, 3)) send_frame($urandom_range(1, 9), $urandom_range(1, 6));
      end_burst();
      drain();
    end
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
